// File: sv/aru_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Aligned run unit allocator package
// Shared constants, codes, types and the word mask helper.
// ----------------------------------------------------------------------------
package aru_pkg;

    localparam int UNIT_COUNT = 4096;
    localparam int MAX_RUN    = 255;
    localparam int WORD_W     = 64;
    localparam int WORD_COUNT = UNIT_COUNT / WORD_W;
    localparam int ADDR_W     = $clog2(WORD_COUNT);
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int UNIT_W     = $clog2(UNIT_COUNT);
    localparam int SPAN_W     = UNIT_W + 1;
    localparam int LEN_W      = 8;
    localparam int CHUNK_W    = 8;
    localparam int CSEL_W     = $clog2(WORD_W / CHUNK_W);
    localparam int CPOS_W     = $clog2(UNIT_COUNT / CHUNK_W);

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_BADLEN  = 2'd2
    } status_t;

    typedef enum logic {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } func_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WR_FETCH,
        S_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic step;
    } scan_ctrl_t;

    typedef struct packed {
        logic              found;
        logic [UNIT_W-1:0] base;
        logic              word_end;
        logic              map_end;
        logic [ADDR_W-1:0] next_addr;
    } scan_stat_t;

    // Bits of word idx that lie inside the unit range [lo, hi).
    function automatic logic [WORD_W-1:0] range_mask(
        input logic [ADDR_W-1:0] idx,
        input logic [SPAN_W-1:0] lo,
        input logic [SPAN_W-1:0] hi
    );
        logic [SPAN_W-1:0] ws;
        logic [SPAN_W-1:0] we;
        logic [BIT_W-1:0]  s;
        logic [BIT_W:0]    e;
        logic [BIT_W:0]    sh;
        begin
            ws = {1'b0, idx, {BIT_W{1'b0}}};
            we = ws + SPAN_W'(WORD_W);
            s  = (lo > ws) ? BIT_W'(lo - ws) : '0;
            e  = (hi < we) ? (BIT_W + 1)'(hi - ws) : (BIT_W + 1)'(WORD_W);
            sh = (BIT_W + 1)'(WORD_W) - e;
            range_mask = ({WORD_W{1'b1}} << s) & ({WORD_W{1'b1}} >> sh);
        end
    endfunction

endpackage
`default_nettype wire

// File: sv/aru_map_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Aligned run unit allocator bitmap memory
// One write and one registered read port; entries read as free until written.
// ----------------------------------------------------------------------------
module aru_map_ram
    import aru_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WORD_W-1:0] rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WORD_W-1:0] wr_data
);

    logic [WORD_W-1:0]     mem [WORD_COUNT];
    logic [WORD_COUNT-1:0] valid_reg;
    logic [WORD_W-1:0]     rd_data_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= '0;
        end
        else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// File: sv/aru_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Aligned run unit allocator scanner
// Walks the bitmap eight units per cycle while stepped and finds the first free aligned run.
// ----------------------------------------------------------------------------
module aru_scan
    import aru_pkg::*;
(
    input  wire logic              clk,
    input  wire scan_ctrl_t        ctrl,
    input  wire logic [LEN_W-1:0]  run_len,
    input  wire logic [WORD_W-1:0] word,
    output scan_stat_t             stat
);

    logic [CPOS_W-1:0] chunk_reg;
    logic [CPOS_W-1:0] chunk_next;
    logic [UNIT_W-1:0] cand_reg;
    logic [UNIT_W-1:0] cand_next;
    logic [LEN_W-1:0]  off_reg;
    logic [LEN_W-1:0]  off_next;
    logic              clean_reg;
    logic              clean_next;
    logic              found;
    logic [UNIT_W-1:0] found_base;
    logic [CHUNK_W-1:0] bits;
    logic [CSEL_W-1:0] csel;
    logic [LEN_W-1:0]  len_m1;

    assign csel   = chunk_reg[CSEL_W-1:0];
    assign bits   = word[{csel, {$clog2(CHUNK_W){1'b0}}} +: CHUNK_W];
    assign len_m1 = run_len - LEN_W'(1);

    always_comb begin
        logic [UNIT_W-1:0] c;
        logic [LEN_W-1:0]  o;
        logic              cl;
        logic              f;
        c  = cand_reg;
        o  = off_reg;
        cl = clean_reg;
        f  = 1'b0;
        for (int i = 0; i < CHUNK_W; i++) begin
            if (!f) begin
                cl = cl & ~bits[i];
                if (o == len_m1) begin
                    if (cl) begin
                        f = 1'b1;
                    end
                    else begin
                        c  = UNIT_W'(CHUNK_W * chunk_reg + i + 1);
                        o  = '0;
                        cl = 1'b1;
                    end
                end
                else begin
                    o = o + LEN_W'(1);
                end
            end
        end
        found      = f;
        found_base = c;
        cand_next  = c;
        off_next   = o;
        clean_next = cl;
        chunk_next = chunk_reg + CPOS_W'(1);
        if (ctrl.start) begin
            cand_next  = '0;
            off_next   = '0;
            clean_next = 1'b1;
            chunk_next = '0;
        end
        else if (!ctrl.step) begin
            cand_next  = cand_reg;
            off_next   = off_reg;
            clean_next = clean_reg;
            chunk_next = chunk_reg;
        end
    end

    always_ff @(posedge clk) begin
        chunk_reg <= chunk_next;
        cand_reg  <= cand_next;
        off_reg   <= off_next;
        clean_reg <= clean_next;
    end

    assign stat.found     = found;
    assign stat.base      = found_base;
    assign stat.word_end  = (csel == {CSEL_W{1'b1}});
    assign stat.map_end   = (chunk_reg == {CPOS_W{1'b1}});
    assign stat.next_addr = chunk_reg[CPOS_W-1:CSEL_W] + ADDR_W'(1);

endmodule
`default_nettype wire

// File: sv/aligned_run_unit_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Aligned run unit allocator
// Allocates aligned runs of units and frees runs of units in a 4096-unit used/free bitmap.
// ----------------------------------------------------------------------------
// The bitmap lives in a 64 by 64-bit memory and handles one item at a time.
// An allocate scans the map from unit 0 at eight units per cycle and stops at
// the first free run aligned to the run length, then fetches the first map
// word the run touches and does one read-modify-write per word touched. A
// free fetches and rewrites each word that its run touches in the same way.
// A zero run length goes straight to the result.
// Each item yields one result, held in an output register, and the next
// item is accepted while that result waits.
// ----------------------------------------------------------------------------
module aligned_run_unit_allocator
    import aru_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              func,
    input  wire logic [LEN_W-1:0]  run_length,
    input  wire logic [UNIT_W-1:0] base_unit,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [1:0]             status,
    output logic [UNIT_W-1:0]      granted_base
);

    state_t state_reg;
    state_t state_next;

    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;
    logic              set_reg;
    logic              set_next;
    logic [SPAN_W-1:0] lo_reg;
    logic [SPAN_W-1:0] lo_next;
    logic [SPAN_W-1:0] hi_reg;
    logic [SPAN_W-1:0] hi_next;
    logic [ADDR_W-1:0] wr_word_reg;
    logic [ADDR_W-1:0] wr_word_next;
    status_t           res_status_reg;
    status_t           res_status_next;
    logic [UNIT_W-1:0] res_base_reg;
    logic [UNIT_W-1:0] res_base_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [1:0]        out_status_reg;
    logic [UNIT_W-1:0] out_base_reg;

    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [WORD_W-1:0] ram_rd_data;
    logic              ram_wr_en;
    logic [WORD_W-1:0] ram_wr_data;
    scan_ctrl_t        scan_ctrl;
    scan_stat_t        scan_stat;

    logic              is_free;
    logic              bad_len;
    logic [SPAN_W-1:0] free_end;
    logic [SPAN_W-1:0] hi_m1;
    logic              last_word;
    logic [WORD_W-1:0] mask;
    logic              out_load;

    assign is_free   = (func_t'(func) == FUNC_FREE);
    assign bad_len   = (run_length == '0)
                    || ((LEN_W + 1)'(run_length) > (LEN_W + 1)'(MAX_RUN));
    assign free_end  = {1'b0, base_unit} + SPAN_W'(run_length);
    assign hi_m1     = hi_reg - SPAN_W'(1);
    assign last_word = (wr_word_reg == hi_m1[UNIT_W-1:BIT_W]);
    assign mask      = range_mask(wr_word_reg, lo_reg, hi_reg);
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    aru_map_ram u_map_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data),
        .wr_en   (ram_wr_en),
        .wr_addr (wr_word_reg),
        .wr_data (ram_wr_data)
    );

    aru_scan u_scan (
        .clk     (clk),
        .ctrl    (scan_ctrl),
        .run_len (len_reg),
        .word    (ram_rd_data),
        .stat    (scan_stat)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid) begin
                    if (is_free) begin
                        state_next = (run_length == '0) ? S_DONE : S_WR_FETCH;
                    end
                    else begin
                        state_next = bad_len ? S_DONE : S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_stat.found) begin
                    state_next = S_WR_FETCH;
                end
                else if (scan_stat.map_end) begin
                    state_next = S_DONE;
                end
            end
            S_WR_FETCH:
            begin
                state_next = S_WR;
            end
            S_WR:
            begin
                if (last_word) begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready        = 1'b0;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = '0;
        ram_wr_en       = 1'b0;
        ram_wr_data     = set_reg ? (ram_rd_data | mask) : (ram_rd_data & ~mask);
        scan_ctrl.start = 1'b0;
        scan_ctrl.step  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready        = 1'b1;
                scan_ctrl.start = 1'b1;
                ram_rd_en       = in_valid && !is_free && !bad_len;
            end
            S_SCAN:
            begin
                scan_ctrl.step = 1'b1;
                ram_rd_en      = scan_stat.word_end && !scan_stat.found
                              && !scan_stat.map_end;
                ram_rd_addr    = scan_stat.next_addr;
            end
            S_WR_FETCH:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = lo_reg[UNIT_W-1:BIT_W];
            end
            S_WR:
            begin
                ram_wr_en   = 1'b1;
                ram_rd_en   = !last_word;
                ram_rd_addr = wr_word_reg + ADDR_W'(1);
            end
            S_DONE:
            begin
                in_ready = 1'b0;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        len_next        = len_reg;
        set_next        = set_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        wr_word_next    = wr_word_reg;
        res_status_next = res_status_reg;
        res_base_next   = res_base_reg;
        case (state_reg)
            S_IDLE:
            begin
                len_next      = run_length;
                set_next      = !is_free;
                lo_next       = {1'b0, base_unit};
                hi_next       = (free_end > SPAN_W'(UNIT_COUNT)) ? SPAN_W'(UNIT_COUNT)
                                                                 : free_end;
                res_base_next = '0;
                if (is_free) begin
                    res_status_next = ST_OK;
                end
                else begin
                    res_status_next = bad_len ? ST_BADLEN : ST_NOSPACE;
                end
            end
            S_SCAN:
            begin
                if (scan_stat.found) begin
                    lo_next         = {1'b0, scan_stat.base};
                    hi_next         = {1'b0, scan_stat.base} + SPAN_W'(len_reg);
                    res_status_next = ST_OK;
                    res_base_next   = scan_stat.base;
                end
            end
            S_WR_FETCH:
            begin
                wr_word_next = lo_reg[UNIT_W-1:BIT_W];
            end
            S_WR:
            begin
                wr_word_next = wr_word_reg + ADDR_W'(1);
            end
            default:
            begin
                wr_word_next = wr_word_reg;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end
        else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        len_reg        <= len_next;
        set_reg        <= set_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        wr_word_reg    <= wr_word_next;
        res_status_reg <= res_status_next;
        res_base_reg   <= res_base_next;
        if (out_load) begin
            out_status_reg <= res_status_reg;
            out_base_reg   <= res_base_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign granted_base = out_base_reg;

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aligned run unit allocator testbench
// Drives allocate and free items through the valid/ready input and checks
// every result against a bitmap predictor under several idle and stall mixes.
// ----------------------------------------------------------------------------
module testbench;
    import aru_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_CYCLES = 700;
    localparam int SETTLE_CYCLES = 600;

    typedef struct packed {
        func_t             op;
        logic [LEN_W-1:0]  len;
        logic [UNIT_W-1:0] base;
    } request_t;

    typedef struct packed {
        status_t           status;
        logic [UNIT_W-1:0] base;
    } grant_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic func = FUNC_ALLOC;
    logic [LEN_W-1:0] run_length = '0;
    logic [UNIT_W-1:0] base_unit = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [1:0] status;
    logic [UNIT_W-1:0] granted_base;

    request_t pending[$];
    request_t live_runs[$];
    grant_t expected_results[$];
    bit [UNIT_COUNT-1:0] unit_map = '0;
    request_t offered;
    grant_t want;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_asked = 0;
    int hold_served = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int mismatch_count = 0;
    int item_count = 0;
    int result_count = 0;
    int grant_count = 0;
    int nospace_count = 0;
    int badlen_count = 0;
    int free_count = 0;

    aligned_run_unit_allocator uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .func(func),
        .run_length(run_length),
        .base_unit(base_unit),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .granted_base(granted_base)
    );

    always #5 clk = ~clk;

    task automatic predict_grant(input request_t req);
        grant_t res;
        int unsigned lim;
        int unsigned n;
        int unsigned k;
        bit fits;
        res.status = ST_OK;
        res.base = '0;
        item_count++;
        if (req.op == FUNC_FREE) begin
            for (k = 0; k < req.len; k++)
                if (req.base + k < UNIT_COUNT)
                    unit_map[req.base + k] = 1'b0;
            free_count++;
        end
        else if (req.len == 0 || req.len > MAX_RUN) begin
            res.status = ST_BADLEN;
            badlen_count++;
        end
        else begin
            lim = UNIT_COUNT - (UNIT_COUNT % req.len);
            res.status = ST_NOSPACE;
            for (n = 0; n < lim && res.status == ST_NOSPACE; n += req.len) begin
                fits = 1'b1;
                for (k = 0; k < req.len && fits; k++)
                    if (unit_map[n + k])
                        fits = 1'b0;
                if (fits) begin
                    for (k = 0; k < req.len; k++)
                        unit_map[n + k] = 1'b1;
                    res.status = ST_OK;
                    res.base = n[UNIT_W-1:0];
                end
            end
            if (res.status == ST_OK) begin
                grant_count++;
                live_runs.push_back('{op: FUNC_FREE, len: req.len, base: res.base});
            end
            else begin
                nospace_count++;
            end
        end
        expected_results.push_back(res);
    endtask

    function automatic request_t random_request();
        request_t req;
        int pick;
        int slot;
        pick = $urandom_range(99);
        req.base = UNIT_W'($urandom_range(0, UNIT_COUNT - 1));
        if (pick < 50) begin
            req.op = FUNC_ALLOC;
            pick = $urandom_range(9);
            if (pick < 6)
                req.len = LEN_W'($urandom_range(1, 16));
            else if (pick < 9)
                req.len = LEN_W'($urandom_range(17, 128));
            else
                req.len = LEN_W'($urandom_range(129, MAX_RUN));
        end
        else if (pick < 88 && live_runs.size() > 0) begin
            slot = $urandom_range(0, live_runs.size() - 1);
            req = live_runs[slot];
            live_runs.delete(slot);
            if ($urandom_range(5) == 0)
                req.len = LEN_W'($urandom_range(1, req.len));
        end
        else begin
            pick = $urandom_range(3);
            req.op = (pick == 0) ? FUNC_ALLOC : FUNC_FREE;
            req.len = (pick >= 2) ? LEN_W'($urandom_range(0, MAX_RUN)) : '0;
        end
        return req;
    endfunction

    task automatic push_req(input func_t op, input int len, input int base);
        pending.push_back('{op: op, len: LEN_W'(len), base: UNIT_W'(base)});
    endtask

    task automatic drain();
        while (pending.size() > 0 || in_valid || expected_results.size() > 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input int items, input int send_pct, input int recv_pct,
                             input int hold_at);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < items; i++) begin
            while (pending.size() >= 2)
                @(negedge clk);
            if (i == hold_at)
                hold_asked++;
            pending.push_back(random_request());
        end
        drain();
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            func <= FUNC_ALLOC;
            run_length <= '0;
            base_unit <= '0;
        end
        else begin
            if (in_valid && in_ready)
                predict_grant(offered);
            if (!in_valid || in_ready) begin
                if (pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered = pending.pop_front();
                    in_valid <= 1'b1;
                    func <= offered.op;
                    run_length <= offered.len;
                    base_unit <= offered.base;
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (hold_asked != hold_served) begin
            hold_left <= HOLD_CYCLES;
            hold_served <= hold_asked;
        end
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else begin
            if (out_valid && out_ready) begin
                result_count++;
                if (expected_results.size() == 0) begin
                    $error("Result with no item waiting: status %0d, granted_base %0d",
                           status, granted_base);
                    mismatch_count++;
                end
                else begin
                    want = expected_results.pop_front();
                    if (status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        mismatch_count++;
                    end
                    if (granted_base !== want.base) begin
                        $error("granted_base: expected %0d, actual %0d",
                               want.base, granted_base);
                        mismatch_count++;
                    end
                end
            end
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("Timed out after %0d cycles with %0d results outstanding",
                   cycle_count, expected_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push_req(FUNC_ALLOC, 0, UNIT_COUNT - 1);
        push_req(FUNC_FREE, 0, 0);
        push_req(FUNC_ALLOC, 1, 0);
        push_req(FUNC_ALLOC, MAX_RUN, 2730);
        push_req(FUNC_ALLOC, 3, 1365);
        push_req(FUNC_ALLOC, 128, 0);
        push_req(FUNC_FREE, MAX_RUN, UNIT_COUNT - 1);
        push_req(FUNC_FREE, MAX_RUN, 0);
        for (int i = 0; i < 17; i++)
            push_req(FUNC_ALLOC, MAX_RUN, 0);
        push_req(FUNC_ALLOC, 1, UNIT_COUNT - 1);
        drain();

        run_phase(157, 0, 0, 30);
        run_phase(157, 70, 0, -1);
        run_phase(157, 0, 70, -1);
        run_phase(157, 31, 31, -1);

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Covered %0d items: %0d grants, %0d no-space, %0d zero-length, %0d frees.",
                 item_count, grant_count, nospace_count, badlen_count, free_count);
        $display("Checked %0d results over four idle/stall mixes and a long output hold-off.",
                 result_count);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// File: filelist.f
sv/aru_pkg.sv
sv/aru_map_ram.sv
sv/aru_scan.sv
sv/aligned_run_unit_allocator.sv
tb/testbench.sv
